@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ design/rci_pkg.sv @@
// Package: widths, word types and cosine table for the joint interpolator.
package rci_pkg;

    localparam int JOINT_W    = 3;
    localparam int POS_W      = 12;
    localparam int DISP_W     = 13;
    localparam int STEP_W     = 10;
    localparam int DUR_W      = 10;
    localparam int PHASE_W    = 16;
    localparam int COS_W      = 16;
    localparam int COS_N      = 256;
    localparam int COS_IDX_W  = $clog2(COS_N);
    localparam int W_W        = 17;
    localparam int POSX_W     = 16;
    localparam int DIV_STAGES = PHASE_W;
    localparam int LATENCY    = DIV_STAGES + 7;

    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(100);
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned COS_M   = COS_N - 1;

    typedef logic signed [COS_W-1:0] cos_word_t;
    typedef cos_word_t [COS_N-1:0] cos_tab_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic [POS_W-1:0]         start;
        logic signed [DISP_W-1:0] disp;
        logic                     overrun;
        logic                     last;
    } side_t;

    typedef struct packed {
        logic                 valid;
        logic [PHASE_W-1:0]   phase;
        side_t                side;
    } phase_word_t;

    typedef struct packed {
        logic                 valid;
        logic [W_W-1:0]       w;
        side_t                side;
    } weight_word_t;

    // Taylor term n divisor: (2n-1)(2n) for cos, (2n)(2n+1) for sin
    function automatic longint unsigned series_div(longint unsigned x, bit odd, int n);
        longint unsigned q;
        q = 64'd0;
        case (n)
            1:       q = odd ? x / 64'd6   : x / 64'd2;
            2:       q = odd ? x / 64'd20  : x / 64'd12;
            3:       q = odd ? x / 64'd42  : x / 64'd30;
            4:       q = odd ? x / 64'd72  : x / 64'd56;
            5:       q = odd ? x / 64'd110 : x / 64'd90;
            6:       q = odd ? x / 64'd156 : x / 64'd132;
            7:       q = odd ? x / 64'd210 : x / 64'd182;
            8:       q = odd ? x / 64'd272 : x / 64'd240;
            9:       q = odd ? x / 64'd342 : x / 64'd306;
            default: q = odd ? x / 64'd420 : x / 64'd380;
        endcase
        return q;
    endfunction

    // Q30 Taylor series: cos(t) or sin(t), t in [0, pi/4]
    function automatic longint unsigned series_q30(longint unsigned t, bit odd);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t2   = (t * t) >> 30;
        term = odd ? t : Q30_ONE;
        sum  = longint'(term);
        for (int n = 1; n <= 10; n++)
        begin
            term = series_div(term * t2, odd, n);
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        return longint'(sum);
    endfunction

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t        tab;
        longint unsigned k;
        longint unsigned v;
        longint unsigned e;
        bit              neg;
        for (int i = 0; i < COS_N; i++)
        begin
            k   = longint'(i);
            neg = 1'b0;
            if (2 * k > COS_M)
            begin
                k   = COS_M - k;
                neg = 1'b1;
            end
            if (4 * k <= COS_M)
                v = series_q30(PI_Q30 * k / COS_M, 1'b0);
            else
                v = series_q30(PI_Q30 * (COS_M - 2 * k) / (2 * COS_M), 1'b1);
            e = (v * 64'd32768 + (64'd1 << 29)) >> 30;
            if (e > 64'd32767)
                e = 64'd32767;
            tab[i] = neg ? -COS_W'(e) : COS_W'(e);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

@@ design/rci_div.sv @@
// Pipelined restoring divider: phase = (step << 16) / duration, one bit per stage.
module rci_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [rci_pkg::STEP_W-1:0] in_step,
    input  logic [rci_pkg::DUR_W-1:0]  in_dur,
    input  rci_pkg::side_t             in_side,
    output rci_pkg::phase_word_t       out_word
);
    import rci_pkg::*;

    logic                 valid_reg [DIV_STAGES];
    logic [DUR_W-1:0]     rem_reg   [DIV_STAGES];
    logic [PHASE_W-1:0]   quo_reg   [DIV_STAGES];
    logic [DUR_W-1:0]     dvs_reg   [DIV_STAGES];
    side_t                side_reg  [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            logic               v_in;
            logic [DUR_W-1:0]   r_in;
            logic [PHASE_W-1:0] q_in;
            logic [DUR_W-1:0]   d_in;
            side_t              s_in;
            logic [DUR_W:0]     r2;
            logic               ge;
            logic [DUR_W-1:0]   rem_next;
            logic [PHASE_W-1:0] quo_next;

            if (g == 0)
            begin : g_first
                assign v_in = in_valid;
                assign r_in = DUR_W'(in_step);
                assign q_in = '0;
                assign d_in = in_dur;
                assign s_in = in_side;
            end
            else
            begin : g_rest
                assign v_in = valid_reg[g-1];
                assign r_in = rem_reg[g-1];
                assign q_in = quo_reg[g-1];
                assign d_in = dvs_reg[g-1];
                assign s_in = side_reg[g-1];
            end

            always_comb
            begin
                r2       = {r_in, 1'b0};
                ge       = r2 >= {1'b0, d_in};
                rem_next = ge ? DUR_W'(r2 - {1'b0, d_in}) : DUR_W'(r2);
                quo_next = {q_in[PHASE_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else
                    valid_reg[g] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                dvs_reg[g]  <= d_in;
                side_reg[g] <= s_in;
            end
        end
    endgenerate

    assign out_word.valid = valid_reg[DIV_STAGES-1];
    assign out_word.phase = quo_reg[DIV_STAGES-1];
    assign out_word.side  = side_reg[DIV_STAGES-1];

endmodule

@@ design/rci_interp.sv @@
// Cosine table lookup, linear interpolation and weight w = 0.5 - cos/2 in Q0.16.
module rci_interp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rci_pkg::phase_word_t   in_word,
    output rci_pkg::weight_word_t  out_word
);
    import rci_pkg::*;

    localparam int P_W    = PHASE_W + COS_IDX_W;
    localparam int DIFF_W = COS_W + 1;
    localparam int PROD_W = DIFF_W + PHASE_W + 1;
    localparam int S_W    = PROD_W + 1;

    // lookup stage
    logic                  lut_valid_reg;
    cos_word_t             t0_reg;
    cos_word_t             t1_reg;
    logic [PHASE_W-1:0]    f_reg;
    side_t                 lut_side_reg;

    // product stage
    logic                  mul_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    cos_word_t             mt0_reg;
    side_t                 mul_side_reg;

    // weight stage
    logic                  w_valid_reg;
    logic [W_W-1:0]        w_reg;
    side_t                 w_side_reg;

    logic [P_W-1:0]        p;
    logic [COS_IDX_W-1:0]  idx;
    logic [COS_IDX_W-1:0]  idx_next;
    cos_word_t             t0_next;
    cos_word_t             t1_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [S_W-1:0]    s;
    logic signed [DIFF_W-1:0] c;
    logic [W_W-1:0]           w_next;

    always_comb
    begin
        p = (P_W'(in_word.phase) << COS_IDX_W) - P_W'(in_word.phase);
        idx = p[P_W-1:PHASE_W];
        if (idx > COS_IDX_W'(COS_N - 2))
            idx = COS_IDX_W'(COS_N - 2);
        idx_next = idx + COS_IDX_W'(1);
        t0_next  = COS_TAB[idx];
        t1_next  = COS_TAB[idx_next];
    end

    always_comb
    begin
        diff      = DIFF_W'(t1_reg) - DIFF_W'(t0_reg);
        prod_next = PROD_W'(diff) * $signed({1'b0, f_reg});
    end

    always_comb
    begin
        s      = (S_W'(mt0_reg) <<< PHASE_W) + S_W'(prod_reg) + S_W'(32768);
        c      = s[PHASE_W +: DIFF_W];
        w_next = W_W'(32'sd32768 - 32'(c));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            w_valid_reg   <= 1'b0;
        end
        else
        begin
            lut_valid_reg <= in_word.valid;
            mul_valid_reg <= lut_valid_reg;
            w_valid_reg   <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        f_reg        <= p[PHASE_W-1:0];
        lut_side_reg <= in_word.side;
        prod_reg     <= prod_next;
        mt0_reg      <= t0_reg;
        mul_side_reg <= lut_side_reg;
        w_reg        <= w_next;
        w_side_reg   <= mul_side_reg;
    end

    assign out_word.valid = w_valid_reg;
    assign out_word.w     = w_reg;
    assign out_word.side  = w_side_reg;

endmodule

@@ design/rci_blend.sv @@
// Weight times displacement, rounding, end clamp and saturation to the position range.
module rci_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rci_pkg::weight_word_t       in_word,
    output logic                        done,
    output logic [rci_pkg::JOINT_W-1:0] joint_out,
    output logic [rci_pkg::POS_W-1:0]   setpoint,
    output logic                        clipped,
    output logic                        last_step,
    output logic                        step_overrun
);
    import rci_pkg::*;

    localparam int PROD_W = W_W + 1 + DISP_W;
    localparam int SUM_W  = 32;

    logic                      mul_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    side_t                     mul_side_reg;

    logic                      pos_valid_reg;
    logic signed [POSX_W-1:0]  pos_reg;
    side_t                     pos_side_reg;

    logic                      done_reg;
    logic [JOINT_W-1:0]        joint_reg;
    logic [POS_W-1:0]          setpoint_reg;
    logic                      clipped_reg;
    logic                      last_reg;
    logic                      overrun_reg;

    logic signed [PROD_W-1:0]  prod_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [POSX_W-1:0]  pos_next;
    logic [POS_W-1:0]          setpoint_next;
    logic                      clipped_next;

    assign prod_next = PROD_W'($signed({1'b0, in_word.w})) * PROD_W'(in_word.side.disp);

    always_comb
    begin
        sum = (SUM_W'($signed({1'b0, mul_side_reg.start})) <<< PHASE_W)
            + SUM_W'(prod_reg) + SUM_W'(32768);
        if (mul_side_reg.overrun)
            pos_next = POSX_W'($signed({1'b0, mul_side_reg.start}))
                     + POSX_W'(mul_side_reg.disp);
        else
            pos_next = sum[PHASE_W +: POSX_W];
    end

    always_comb
    begin
        if (pos_reg < 0)
        begin
            setpoint_next = '0;
            clipped_next  = 1'b1;
        end
        else if (pos_reg > POSX_W'(POS_MAX))
        begin
            setpoint_next = POS_MAX;
            clipped_next  = 1'b1;
        end
        else
        begin
            setpoint_next = pos_reg[POS_W-1:0];
            clipped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            pos_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_word.valid;
            pos_valid_reg <= mul_valid_reg;
            done_reg      <= pos_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        mul_side_reg <= in_word.side;
        pos_reg      <= pos_next;
        pos_side_reg <= mul_side_reg;
        joint_reg    <= pos_side_reg.joint;
        setpoint_reg <= setpoint_next;
        clipped_reg  <= clipped_next;
        last_reg     <= pos_side_reg.last;
        overrun_reg  <= pos_side_reg.overrun;
    end

    assign done         = done_reg;
    assign joint_out    = joint_reg;
    assign setpoint     = setpoint_reg;
    assign clipped      = clipped_reg;
    assign last_step    = last_reg;
    assign step_overrun = overrun_reg;

endmodule

@@ design/raised_cosine_joint_interpolator.sv @@
// Top level: raised-cosine joint setpoint interpolator.
//
// Request channel: drive joint_index, start_position, displacement and
// step_index with start high; the word is taken at any clock edge where
// busy is low. busy is never raised, so a word can enter every cycle.
// Result channel: done is high for one cycle with joint_out, setpoint,
// clipped, last_step and step_overrun. The receiver cannot stall it.
// Pipeline: between the accepting edge and done the word passes the input
// register, 16 divider stages, lookup, interpolation product, weight,
// displacement product, sum and output register.
// Throughput: one word per cycle; the one-bit-per-stage divider that
// turns step/duration into a phase sets the pipeline depth.
// Results come out in request order.
// Config: APB register 0 at byte address 0 is move_duration (10 bits);
// write only while no request is in flight. Other addresses read as 0.
// Reset: rst_n clears all valid bits and sets move_duration to 100.
module raised_cosine_joint_interpolator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rci_pkg::JOINT_W-1:0] joint_index,
    input  logic [rci_pkg::POS_W-1:0]   start_position,
    input  logic signed [rci_pkg::DISP_W-1:0] displacement,
    input  logic [rci_pkg::STEP_W-1:0]  step_index,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        done,
    output logic [rci_pkg::JOINT_W-1:0] joint_out,
    output logic [rci_pkg::POS_W-1:0]   setpoint,
    output logic                        clipped,
    output logic                        last_step,
    output logic                        step_overrun
);
    import rci_pkg::*;

    localparam logic [1:0] ADDR_DURATION = 2'b00;

    logic [DUR_W-1:0]   dur_reg;
    logic [DUR_W-1:0]   dur_next;
    logic               cfg_write;

    logic               in_valid_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DUR_W-1:0]   in_dur_reg;
    side_t              side_reg;
    side_t              side_next;

    phase_word_t        phase_word;
    weight_word_t       weight_word;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign busy      = 1'b0;

    always_comb
    begin
        dur_next = dur_reg;
        if (cfg_write && paddr == ADDR_DURATION)
            dur_next = pwdata[DUR_W-1:0];
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_DURATION: prdata = 32'(dur_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        side_next.joint   = joint_index;
        side_next.start   = start_position;
        side_next.disp    = displacement;
        side_next.overrun = step_index >= dur_reg;
        side_next.last    = ({1'b0, step_index} + (STEP_W+1)'(1)) == {1'b0, dur_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg      <= DUR_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            dur_reg      <= dur_next;
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_index;
        in_dur_reg <= dur_reg;
        side_reg   <= side_next;
    end

    rci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_step  (step_reg),
        .in_dur   (in_dur_reg),
        .in_side  (side_reg),
        .out_word (phase_word)
    );

    rci_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (phase_word),
        .out_word (weight_word)
    );

    rci_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (weight_word),
        .done         (done),
        .joint_out    (joint_out),
        .setpoint     (setpoint),
        .clipped      (clipped),
        .last_step    (last_step),
        .step_overrun (step_overrun)
    );

endmodule

@@ design/rci_checker.sv @@
// Port-level checker for the joint interpolator, bound to the top level.
`include "assert_macros.svh"

module rci_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        pready,
    input logic                        done,
    input logic [rci_pkg::POS_W-1:0]   setpoint,
    input logic                        clipped,
    input logic                        last_step,
    input logic                        step_overrun
);
    import rci_pkg::*;

    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy && pready)
    `ASSERT_IMPL(a_clip_at_rail, clk, rst_n, done && clipped, setpoint == '0 || setpoint == POS_MAX)
    `ASSERT_IMPL(a_last_not_overrun, clk, rst_n, done, !(last_step && step_overrun))
    `ASSERT_IMPL(a_latency, clk, rst_n, done, $past(start, LATENCY))

endmodule

bind raised_cosine_joint_interpolator rci_checker u_rci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pready       (pready),
    .done         (done),
    .setpoint     (setpoint),
    .clipped      (clipped),
    .last_step    (last_step),
    .step_overrun (step_overrun)
);

@@ tb/raised_cosine_joint_interpolator_tb.sv @@
// Self-checking testbench for the raised-cosine joint setpoint interpolator.
`timescale 1ns / 1ps

module raised_cosine_joint_interpolator_tb;

    import rci_pkg::*;

    localparam logic [1:0] DURATION_ADDR = 2'd0;
    localparam logic [1:0] UNMAPPED_ADDR = 2'd2;
    localparam int TAIL_CYCLES = LATENCY + 8;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [POS_W-1:0]   setpoint;
        logic               clipped;
        logic               last;
        logic               overrun;
    } setpoint_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [JOINT_W-1:0]        joint_index;
    logic [POS_W-1:0]          start_position;
    logic signed [DISP_W-1:0]  displacement;
    logic [STEP_W-1:0]         step_index;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [1:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      done;
    logic [JOINT_W-1:0]        joint_out;
    logic [POS_W-1:0]          setpoint;
    logic                      clipped;
    logic                      last_step;
    logic                      step_overrun;

    setpoint_word_t pending_setpoints[$];
    setpoint_word_t oldest;
    int             cos_q15[COS_N];
    logic [DUR_W-1:0] duration_setting;
    int             sender_idle_pct;
    int             words_sent;
    int             results_checked;
    int             duration_writes;
    int             errors;

    raised_cosine_joint_interpolator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .joint_index    (joint_index),
        .start_position (start_position),
        .displacement   (displacement),
        .step_index     (step_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .done           (done),
        .joint_out      (joint_out),
        .setpoint       (setpoint),
        .clipped        (clipped),
        .last_step      (last_step),
        .step_overrun   (step_overrun)
    );

    always #2 clk = ~clk;

    // Q30 Taylor sum: cos(t) when odd is 0, sin(t) when odd is 1
    function automatic longint unsigned taylor_q30(longint unsigned t, bit odd);
        longint unsigned t_sq;
        longint unsigned term;
        longint unsigned a;
        longint          acc;
        t_sq = (t * t) >> 30;
        term = odd ? t : 64'd1073741824;
        acc  = longint'(term);
        for (int n = 1; n <= 10; n++)
        begin
            a    = odd ? 64'(2 * n) : 64'(2 * n - 1);
            term = term * t_sq / (a * (a + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > 64'sd1073741824)
            acc = 64'sd1073741824;
        return longint'(acc);
    endfunction

    task automatic fill_cosine_table();
        longint unsigned span;
        longint unsigned k;
        longint unsigned v;
        longint unsigned e;
        longint unsigned pi_q30;
        bit              neg;
        span   = COS_N - 1;
        pi_q30 = 64'd3373259426;
        for (int i = 0; i < COS_N; i++)
        begin
            k   = i;
            neg = 1'b0;
            if (2 * k > span)
            begin
                k   = span - k;
                neg = 1'b1;
            end
            if (4 * k <= span)
                v = taylor_q30(pi_q30 * k / span, 1'b0);
            else
                v = taylor_q30(pi_q30 * (span - 2 * k) / (2 * span), 1'b1);
            e = (v * 64'd32768 + (64'd1 << 29)) >> 30;
            if (e > 64'd32767)
                e = 64'd32767;
            cos_q15[i] = neg ? -int'(e) : int'(e);
        end
    endtask

    function automatic setpoint_word_t predict_setpoint(logic [JOINT_W-1:0] j,
                                                        logic [POS_W-1:0] s,
                                                        logic signed [DISP_W-1:0] d,
                                                        logic [STEP_W-1:0] st);
        setpoint_word_t r;
        longint pos;
        longint phase;
        longint prod;
        longint idx;
        longint frac;
        longint acc;
        longint c;
        longint w;
        r.joint   = j;
        r.overrun = st >= duration_setting;
        r.last    = (int'(st) + 1) == int'(duration_setting);
        r.clipped = 1'b0;
        if (r.overrun)
            pos = longint'(s) + longint'(d);
        else
        begin
            phase = (longint'(st) << 16) / longint'(duration_setting);
            prod  = phase * (COS_N - 1);
            idx   = prod >>> 16;
            frac  = prod & 64'hFFFF;
            if (idx > COS_N - 2)
                idx = COS_N - 2;
            acc = longint'(cos_q15[idx]) * (65536 - frac)
                + longint'(cos_q15[idx + 1]) * frac;
            c   = (acc + 32768) >>> 16;
            w   = 32768 - c;
            pos = (longint'(s) * 65536 + w * longint'(d) + 32768) >>> 16;
        end
        if (pos < 0)
        begin
            pos       = 0;
            r.clipped = 1'b1;
        end
        else if (pos > longint'(POS_MAX))
        begin
            pos       = longint'(POS_MAX);
            r.clipped = 1'b1;
        end
        r.setpoint = pos[POS_W-1:0];
        return r;
    endfunction

    task automatic send_word(input logic [JOINT_W-1:0] j, input logic [POS_W-1:0] s,
                             input logic signed [DISP_W-1:0] d,
                             input logic [STEP_W-1:0] st);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        joint_index    <= j;
        start_position <= s;
        displacement   <= d;
        step_index     <= st;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_setpoints.push_back(predict_setpoint(j, s, d, st));
        words_sent++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_setpoints.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DURATION_ADDR)
            duration_setting = value[DUR_W-1:0];
        duration_writes++;
    endtask

    task automatic send_random_word();
        logic [POS_W-1:0]         s;
        logic signed [DISP_W-1:0] d;
        logic [STEP_W-1:0]        st;
        int                       pick;
        s    = POS_W'($urandom);
        d    = DISP_W'($urandom);
        st   = STEP_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            s = (pick < 5) ? '0 : POS_MAX;
        pick = $urandom_range(99);
        if (duration_setting != 0)
        begin
            if (pick < 75)
                st = STEP_W'($urandom_range(0, int'(duration_setting) - 1));
            else if (pick < 85)
                st = duration_setting - 1'b1;
        end
        send_word(JOINT_W'($urandom), s, d, st);
    endtask

    task automatic test_reset_duration();
        hold_until_drained();
        send_word(0, 0, 4095, 0);
        send_word(7, 4095, -4096, 50);
        send_word(1, 2048, 4095, 99);
        send_word(2, 4095, 4095, 100);
        send_word(3, 0, -4096, 100);
        send_word(4, 1000, -4096, 1023);
        send_word(5, 3000, 2000, 30);
        send_word(6, 12, -1, 1);
    endtask

    task automatic test_duration_extremes();
        hold_until_drained();
        write_register(DURATION_ADDR, 32'd1);
        send_word(0, 100, 500, 0);
        send_word(1, 100, 500, 1);
        hold_until_drained();
        write_register(DURATION_ADDR, {22'($urandom), 10'd1023});
        send_word(2, 0, 4095, 1022);
        send_word(3, 4095, -4096, 511);
        send_word(4, 50, 1, 1023);
    endtask

    // every step overruns, so no quotient is used
    task automatic test_zero_duration();
        hold_until_drained();
        write_register(DURATION_ADDR, 32'd0);
        send_word(5, 4000, 200, 0);
        send_word(6, 10, -20, 1023);
    endtask

    task automatic test_unmapped_write();
        hold_until_drained();
        write_register(UNMAPPED_ADDR, 32'd5);
        send_word(7, 2000, 1000, 3);
    endtask

    task automatic test_random(input int idle_pct, input int per_setting);
        hold_until_drained();
        sender_idle_pct = idle_pct;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            hold_until_drained();
            case (chunk)
                0: write_register(DURATION_ADDR, $urandom_range(1, 1023));
                1: write_register(DURATION_ADDR, $urandom_range(1, 40));
                default: write_register(DURATION_ADDR, $urandom_range(900, 1023));
            endcase
            for (int n = 0; n < per_setting; n++)
                send_random_word();
        end
        sender_idle_pct = 0;
    endtask

    task automatic compare_field(input string field, input int expv, input int actv);
        if (expv != actv)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_setpoints.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual joint %0d setpoint %0d",
                         $time, joint_out, setpoint);
            end
            else
            begin
                oldest = pending_setpoints.pop_front();
                compare_field("joint_out", oldest.joint, joint_out);
                compare_field("setpoint", oldest.setpoint, setpoint);
                compare_field("clipped", oldest.clipped, clipped);
                compare_field("last_step", oldest.last, last_step);
                compare_field("step_overrun", oldest.overrun, step_overrun);
                results_checked++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        joint_index      = '0;
        start_position   = '0;
        displacement     = '0;
        step_index       = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        duration_setting = DUR_RESET;
        sender_idle_pct  = 0;
        words_sent       = 0;
        results_checked  = 0;
        duration_writes  = 0;
        errors           = 0;
        fill_cosine_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_duration();
        test_duration_extremes();
        test_zero_duration();
        test_unmapped_write();
        test_random(0, 50);
        test_random(87, 50);
        test_random(28, 50);
        test_random(0, 50);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_setpoints.size() != 0)
        begin
            errors++;
            $display("%0t: %0d words never came back", $time, pending_setpoints.size());
        end
        $display("Covered %0d words over %0d register writes, incl. zero and extreme durations",
                 words_sent, duration_writes);
        $display("%0d results compared, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/rci_pkg.sv
design/rci_div.sv
design/rci_interp.sv
design/rci_blend.sv
design/raised_cosine_joint_interpolator.sv
design/rci_checker.sv
tb/raised_cosine_joint_interpolator_tb.sv
